/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; pulled in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/rbsi_pkg.sv */
// shared types and constants of the ray/box slab intersection block
// no dependencies; used by rbsi_axis and ray_box_slab_intersect_top
package rbsi_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CTR_X = 3'd0,
		REG_CTR_Y = 3'd1,
		REG_CTR_Z = 3'd2,
		REG_EXT_X = 3'd3,
		REG_EXT_Y = 3'd4,
		REG_EXT_Z = 3'd5
	} cfg_reg_t;

	// axis that set the near time
	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	// face normal component codes
	localparam logic signed [1:0] NRM_ZERO = 2'sb00;
	localparam logic signed [1:0] NRM_POS  = 2'sb01;
	localparam logic signed [1:0] NRM_NEG  = 2'sb11;

	// per-axis status handed from the slab unit to the merge stages
	typedef struct packed {
		logic slab;     // direction nonzero: entry/exit times are meaningful
		logic in_slab;  // parallel case: start lies within the slab
		logic dir_neg;  // direction sign
	} axis_flags_t;

endpackage

/* sv/rbsi_axis.sv */
// one axis of the slab test: entry and exit times over three register stages
// depends on rbsi_pkg
module rbsi_axis #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic signed [31:0]           start,
	input  logic signed [31:0]           dir,
	input  logic signed [31:0]           recip,
	input  logic signed [31:0]           center,
	input  logic        [30:0]           extent,
	output logic signed [67-FRAC_BITS-1:0] t_entry,
	output logic signed [67-FRAC_BITS-1:0] t_exit,
	output rbsi_pkg::axis_flags_t        flags
);

	localparam int TW = 67 - FRAC_BITS;

	logic signed [32:0]    local_s1;
	logic signed [31:0]    recip_s1;
	logic        [31:0]    rabs_s1;
	logic        [30:0]    ext_s1;
	logic                  slab_s1;
	logic                  dneg_s1;

	logic signed [64:0]    prod_p;
	logic        [62:0]    prod_q;
	logic        [32:0]    local_mag;
	logic signed [TW-1:0]  p_s2;
	logic signed [TW-1:0]  q_s2;
	logic                  slab_s2;
	logic                  dneg_s2;
	logic                  in_slab_s2;

	logic signed [TW-1:0]  tf_s3;
	logic signed [TW-1:0]  tb_s3;
	rbsi_pkg::axis_flags_t flags_s3;

	// stage 1: offset from box center and reciprocal magnitude
	always_ff @(posedge clk) begin
		local_s1 <= {start[31], start} - {center[31], center};
		recip_s1 <= recip;
		rabs_s1  <= recip[31] ? 32'(-recip) : 32'(recip);
		ext_s1   <= extent;
		slab_s1  <= dir != 32'sd0;
		dneg_s1  <= dir[31];
	end

	// stage 2: the two products, floored to the fixed-point scale
	assign prod_p    = local_s1 * recip_s1;
	assign prod_q    = ext_s1 * rabs_s1;
	assign local_mag = local_s1[32] ? 33'(-local_s1) : 33'(local_s1);

	always_ff @(posedge clk) begin
		p_s2       <= TW'(prod_p >>> FRAC_BITS);
		q_s2       <= TW'(prod_q >> FRAC_BITS);
		slab_s2    <= slab_s1;
		dneg_s2    <= dneg_s1;
		in_slab_s2 <= (local_mag <= {2'b00, ext_s1});
	end

	// stage 3: entry and exit times
	always_ff @(posedge clk) begin
		tf_s3            <= -p_s2 - q_s2;
		tb_s3            <= -p_s2 + q_s2;
		flags_s3.slab    <= slab_s2;
		flags_s3.in_slab <= in_slab_s2;
		flags_s3.dir_neg <= dneg_s2;
	end

	assign t_entry = tf_s3;
	assign t_exit  = tb_s3;
	assign flags   = flags_s3;

endmodule

/* sv/ray_box_slab_intersect_top.sv */
// top level of the ray/box slab intersection pipeline
// depends on rbsi_pkg, rbsi_axis and assert_macros.svh

// Fully pipelined segment/box slab test. A transaction is accepted on every
// cycle that start is high; busy is always low. Each transaction yields one
// result, shown on the result ports for one cycle with done high, in
// acceptance order. The seven register stages are: input and center offset,
// the two per-axis products, entry and exit times, near/far merge of X and Y,
// merge of Z, hit range check with the hit-point product, and the saturating
// hit-point add. The receiver cannot stall, so there is no back pressure
// anywhere. Box registers are written through wr_en/wr_index/wr_data and
// should only change while no transaction is in flight.
module ray_box_slab_intersect_top #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] recip_x,
	input  logic signed [31:0] recip_y,
	input  logic signed [31:0] recip_z,
	output logic               done,
	output logic               hit,
	output logic [16:0]        hit_time,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic signed [1:0]  normal_x,
	output logic signed [1:0]  normal_y,
	output logic signed [1:0]  normal_z
);

	`include "assert_macros.svh"

	localparam int TW = 67 - FRAC_BITS;
	localparam int PW = FRAC_BITS + 34;
	localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< FRAC_BITS;

	// configuration registers
	logic signed [31:0] ctr_q [3];
	logic        [30:0] ext_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ctr_q[i] <= '0;
				ext_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				rbsi_pkg::REG_CTR_X: ctr_q[0] <= wr_data;
				rbsi_pkg::REG_CTR_Y: ctr_q[1] <= wr_data;
				rbsi_pkg::REG_CTR_Z: ctr_q[2] <= wr_data;
				rbsi_pkg::REG_EXT_X: ext_q[0] <= wr_data[30:0];
				rbsi_pkg::REG_EXT_Y: ext_q[1] <= wr_data[30:0];
				rbsi_pkg::REG_EXT_Z: ext_q[2] <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// per-axis slab units, stages one to three
	logic signed [31:0]    st_in [3];
	logic signed [31:0]    dv_in [3];
	logic signed [31:0]    rc_in [3];
	logic signed [TW-1:0]  tf_s3 [3];
	logic signed [TW-1:0]  tb_s3 [3];
	rbsi_pkg::axis_flags_t fl_s3 [3];

	assign st_in = '{start_x, start_y, start_z};
	assign dv_in = '{dir_x, dir_y, dir_z};
	assign rc_in = '{recip_x, recip_y, recip_z};

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
			.clk     (clk),
			.start   (st_in[a]),
			.dir     (dv_in[a]),
			.recip   (rc_in[a]),
			.center  (ctr_q[a]),
			.extent  (ext_q[a]),
			.t_entry (tf_s3[a]),
			.t_exit  (tb_s3[a]),
			.flags   (fl_s3[a])
		);
	end

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// start and direction travel along for the hit point
	logic signed [31:0] st_s1 [3], st_s2 [3], st_s3 [3], st_s4 [3], st_s5 [3], st_s6 [3];
	logic signed [31:0] dv_s1 [3], dv_s2 [3], dv_s3 [3], dv_s4 [3], dv_s5 [3];

	always_ff @(posedge clk) begin
		st_s1 <= st_in;
		st_s2 <= st_s1;
		st_s3 <= st_s2;
		st_s4 <= st_s3;
		st_s5 <= st_s4;
		st_s6 <= st_s5;
		dv_s1 <= dv_in;
		dv_s2 <= dv_s1;
		dv_s3 <= dv_s2;
		dv_s4 <= dv_s3;
		dv_s5 <= dv_s4;
	end

	// stage 4: merge X and Y; near updates only on a strictly later entry
	logic signed [TW-1:0] near_xy, far_xy;
	logic                 nv_xy;
	rbsi_pkg::axis_t      ax_xy;
	logic                 neg_xy;

	always_comb begin
		near_xy = tf_s3[0];
		far_xy  = tb_s3[0];
		nv_xy   = fl_s3[0].slab;
		ax_xy   = rbsi_pkg::AX_X;
		neg_xy  = fl_s3[0].dir_neg;
		if (fl_s3[1].slab) begin
			if (!nv_xy || tf_s3[1] > near_xy) begin
				near_xy = tf_s3[1];
				ax_xy   = rbsi_pkg::AX_Y;
				neg_xy  = fl_s3[1].dir_neg;
			end
			if (!nv_xy || tb_s3[1] < far_xy) begin
				far_xy = tb_s3[1];
			end
			nv_xy = 1'b1;
		end
	end

	logic signed [TW-1:0]  near_s4, far_s4, tf_z_s4, tb_z_s4;
	logic                  nv_s4, out_s4;
	rbsi_pkg::axis_t       ax_s4;
	logic                  neg_s4;
	rbsi_pkg::axis_flags_t fl_z_s4;

	always_ff @(posedge clk) begin
		near_s4 <= near_xy;
		far_s4  <= far_xy;
		nv_s4   <= nv_xy;
		ax_s4   <= ax_xy;
		neg_s4  <= neg_xy;
		out_s4  <= (!fl_s3[0].slab && !fl_s3[0].in_slab)
			|| (!fl_s3[1].slab && !fl_s3[1].in_slab);
		tf_z_s4 <= tf_s3[2];
		tb_z_s4 <= tb_s3[2];
		fl_z_s4 <= fl_s3[2];
	end

	// stage 5: merge Z
	logic signed [TW-1:0] near_xyz, far_xyz;
	logic                 nv_xyz;
	rbsi_pkg::axis_t      ax_xyz;
	logic                 neg_xyz;

	always_comb begin
		near_xyz = near_s4;
		far_xyz  = far_s4;
		nv_xyz   = nv_s4;
		ax_xyz   = ax_s4;
		neg_xyz  = neg_s4;
		if (fl_z_s4.slab) begin
			if (!nv_s4 || tf_z_s4 > near_s4) begin
				near_xyz = tf_z_s4;
				ax_xyz   = rbsi_pkg::AX_Z;
				neg_xyz  = fl_z_s4.dir_neg;
			end
			if (!nv_s4 || tb_z_s4 < far_s4) begin
				far_xyz = tb_z_s4;
			end
			nv_xyz = 1'b1;
		end
	end

	logic signed [TW-1:0] near_s5;
	logic                 bad_s5;
	rbsi_pkg::axis_t      ax_s5;
	logic                 neg_s5;

	always_ff @(posedge clk) begin
		near_s5 <= near_xyz;
		bad_s5  <= out_s4 || (!fl_z_s4.slab && !fl_z_s4.in_slab) || !nv_xyz
			|| far_xyz < near_xyz;
		ax_s5   <= ax_xyz;
		neg_s5  <= neg_xyz;
	end

	// stage 6: time range check and near * direction products
	logic signed [FRAC_BITS+1:0] near_short;
	logic signed [PW-1:0]        hprod [3];

	assign near_short = near_s5[FRAC_BITS+1:0];
	for (genvar a = 0; a < 3; a++) begin : g_hprod
		assign hprod[a] = near_short * dv_s5[a];
	end

	logic signed [PW-1:0] prod_s6 [3];
	logic                 hit_s6;
	logic [16:0]          time_s6;
	rbsi_pkg::axis_t      ax_s6;
	logic                 neg_s6;

	always_ff @(posedge clk) begin
		prod_s6 <= hprod;
		hit_s6  <= !bad_s5 && !near_s5[TW-1] && near_s5 <= T_ONE;
		time_s6 <= near_s5[16:0];
		ax_s6   <= ax_s5;
		neg_s6  <= neg_s5;
	end

	// stage 7: saturating hit point and result register
	logic signed [34:0] hsum [3];
	logic signed [31:0] hsat [3];
	logic signed [1:0]  nrm_face;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			hsum[a] = 35'(st_s6[a]) + 35'(prod_s6[a] >>> FRAC_BITS);
			if (hsum[a] > 35'sd2147483647) begin
				hsat[a] = 32'sh7fffffff;
			end else if (hsum[a] < -35'sd2147483648) begin
				hsat[a] = 32'sh80000000;
			end else begin
				hsat[a] = hsum[a][31:0];
			end
		end
		nrm_face = neg_s6 ? rbsi_pkg::NRM_POS : rbsi_pkg::NRM_NEG;
	end

	logic               hit_s7;
	logic [16:0]        time_s7;
	logic signed [31:0] pt_s7 [3];
	logic signed [1:0]  nrm_s7 [3];

	always_ff @(posedge clk) begin
		hit_s7  <= hit_s6;
		time_s7 <= hit_s6 ? time_s6 : 17'd0;
		for (int a = 0; a < 3; a++) begin
			pt_s7[a]  <= hit_s6 ? hsat[a] : 32'sd0;
			nrm_s7[a] <= (hit_s6 && ax_s6 == rbsi_pkg::axis_t'(a))
				? nrm_face : rbsi_pkg::NRM_ZERO;
		end
	end

	assign done     = v_s7;
	assign hit      = hit_s7;
	assign hit_time = time_s7;
	assign hit_x    = pt_s7[0];
	assign hit_y    = pt_s7[1];
	assign hit_z    = pt_s7[2];
	assign normal_x = nrm_s7[0];
	assign normal_y = nrm_s7[1];
	assign normal_z = nrm_s7[2];

	// a miss carries all-zero fields
	`ASSERT_IMPLIES(a_miss_zero, clk, arst_n, done && !hit,
		hit_time == 17'd0 && hit_x == 32'sd0 && hit_y == 32'sd0 && hit_z == 32'sd0
		&& normal_x == rbsi_pkg::NRM_ZERO && normal_y == rbsi_pkg::NRM_ZERO
		&& normal_z == rbsi_pkg::NRM_ZERO)
	// a hit names exactly one entered face and a time within the segment
	`ASSERT_IMPLIES(a_hit_face, clk, arst_n, done && hit,
		$countones({normal_x[0], normal_y[0], normal_z[0]}) == 1
		&& {15'd0, hit_time} <= (32'd1 << FRAC_BITS))
	// an accepted transaction enters the pipeline
	`ASSERT_NEXT(a_accept, clk, arst_n, start && !busy, v_s1)

endmodule
